FILE: src/blca_pkg.sv
// shared types, constants and helper functions for the lca forest unit
// no dependencies; every other file takes names from here, by scope or by import

package blca_pkg;

  // sizes
  localparam int unsigned MAX_NODES  = 1024;
  localparam int unsigned LOG_LEVELS = 10;
  localparam int unsigned ID_W       = 10;
  localparam int unsigned NODE_W     = 11;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned LVL_W      = 4;

  typedef logic [NODE_W-1:0] node_t;

  localparam node_t NODE_NONE = '1;
  localparam node_t DEPTH_MAX = NODE_W'(1023);

  // command codes
  typedef enum logic [1:0] {
    CMD_ADD_ROOT   = 2'd0,
    CMD_ADD_LEAF   = 2'd1,
    CMD_QUERY_LCA  = 2'd2,
    CMD_GET_PARENT = 2'd3
  } cmd_e;

  // one node row: parent, depth, tree root and all jump levels
  typedef struct packed {
    node_t                        parent;
    node_t                        depth;
    node_t                        root;
    node_t [LOG_LEVELS-1:0]       jump;
  } row_t;

  localparam row_t ROW_NONE = '1;

  // table port requests
  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] addr;
    row_t            row;
  } wr_req_t;

  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] addr;
  } rd_req_t;

  // clamp the written count into 1..MAX_NODES
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = v;
    if (c == '0) c = CNT_W'(1);
    if (c > CNT_W'(MAX_NODES)) c = CNT_W'(MAX_NODES);
    return c;
  endfunction

  // index of the highest set bit, zero for values up to one
  function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 1; i < CNT_W; i++) begin
      if (x[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

  // number of jump levels in use for a count
  function automatic logic [LVL_W-1:0] levels_used(input logic [CNT_W-1:0] c);
    logic [LVL_W-1:0] u;
    u = LVL_W'(1);
    for (int j = 1; j < LOG_LEVELS; j++) begin
      if ((CNT_W'(1) << j) < c) u = LVL_W'(j + 1);
    end
    return u;
  endfunction

  // highest level searched during descent
  function automatic logic [LVL_W-1:0] top_level(input logic [CNT_W-1:0] c);
    logic [LVL_W-1:0] t;
    t = floor_log2(c);
    if (t > LVL_W'(LOG_LEVELS - 1)) t = LVL_W'(LOG_LEVELS - 1);
    return t;
  endfunction

endpackage

FILE: src/blca_req_if.sv
// request channel: command and two node ids with valid/ready
// depends on blca_pkg for field widths

interface blca_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [blca_pkg::ID_W-1:0]   node_a;
  logic [blca_pkg::ID_W-1:0]   node_b;

  modport source (output valid, command, node_a, node_b, input ready);
  modport sink   (input valid, command, node_a, node_b, output ready);
endinterface

FILE: src/blca_rsp_if.sv
// response channel: one answer node per word with valid/ready
// depends on blca_pkg for field widths

interface blca_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [blca_pkg::NODE_W-1:0] answer_node;

  modport source (output valid, answer_node, input ready);
  modport sink   (input valid, answer_node, output ready);
endinterface

FILE: src/blca_cfg_if.sv
// configuration write channel carrying the node count register
// depends on blca_pkg for field widths

interface blca_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [blca_pkg::CNT_W-1:0]   node_count;

  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface

FILE: src/blca_table.sv
// node table: one row per node, one write and one registered read per cycle
// depends on blca_pkg for the row and request types

module blca_table (
  input  logic              clk_i,
  input  blca_pkg::wr_req_t wr_i,
  input  blca_pkg::rd_req_t rd_i,
  output blca_pkg::row_t    rdata_o
);

  blca_pkg::row_t mem_q [blca_pkg::MAX_NODES];
  blca_pkg::row_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.addr] <= wr_i.row;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i.en) rdata_q <= mem_q[rd_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/binary_lifting_lca_forest_unit.sv
// Forest of up to 1024 nodes answering lowest-common-ancestor queries by binary lifting.
// Every node keeps one row (parent, depth, root, ten jump levels) in a table with one
// write and one read port, and a small sequencer walks that table one registered read at
// a time, so the table's read port sets the pace. After reset the unit clears the table
// row by row and takes no request word meanwhile (configuration writes are taken). add_root
// writes its row, and a command whose ids are out of range answers none; get_parent reads
// one row; add_leaf reads the parent row, then one row per jump level, but fills a level
// that points back at the node itself without a read; query_lca reads both rows, answers
// none when the trees differ, else lifts the deeper node by the highest remaining power
// of two per step, answering with the other node if the lift lands on it, then descends
// level by level, reading both nodes' rows where both move (only the first once the
// second has no ancestors left); a lift that breaks off ends early. Any answer may wait
// for the output register to free. One request is in work at a time; a finished answer
// waits in an output register while the next request is taken.
// depends on blca_pkg, the three channel interfaces and blca_table

module binary_lifting_lca_forest_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  blca_req_if.sink          req_i,
  blca_rsp_if.source        rsp_o,
  blca_cfg_if.sink          cfg_i
);

  localparam int unsigned ID_W   = blca_pkg::ID_W;
  localparam int unsigned NODE_W = blca_pkg::NODE_W;
  localparam int unsigned CNT_W  = blca_pkg::CNT_W;
  localparam int unsigned LVL_W  = blca_pkg::LVL_W;

  // sequencer states
  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_LEAF_B    = 5'd2;
  localparam logic [4:0] S_LEAF_STEP = 5'd3;
  localparam logic [4:0] S_LEAF_GOT  = 5'd4;
  localparam logic [4:0] S_LEAF_WR   = 5'd5;
  localparam logic [4:0] S_Q_A       = 5'd6;
  localparam logic [4:0] S_Q_B       = 5'd7;
  localparam logic [4:0] S_LIFT      = 5'd8;
  localparam logic [4:0] S_LIFT_GOT  = 5'd9;
  localparam logic [4:0] S_DESC      = 5'd10;
  localparam logic [4:0] S_DESC_U    = 5'd11;
  localparam logic [4:0] S_DESC_V    = 5'd12;
  localparam logic [4:0] S_PARENT    = 5'd13;
  localparam logic [4:0] S_GP        = 5'd14;
  localparam logic [4:0] S_DONE      = 5'd15;

  // control state
  logic [4:0]       state_q, state_d;
  logic [ID_W-1:0]  clr_q, clr_d;
  logic [CNT_W-1:0] cnt_q;
  logic [LVL_W-1:0] used_q, top_q;
  logic             out_valid_q, out_valid_d;

  // working registers
  logic [ID_W-1:0]       a_q, a_d, b_q, b_d;
  blca_pkg::node_t       u_q, u_d, v_q, v_d;
  blca_pkg::row_t        rowu_q, rowu_d, rowv_q, rowv_d;
  logic [ID_W-1:0]       dist_q, dist_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  blca_pkg::node_t       ans_q, ans_d;
  blca_pkg::node_t       out_data_q, out_data_d;

  // table ports
  blca_pkg::wr_req_t wr;
  blca_pkg::rd_req_t rd;
  blca_pkg::row_t    rdata;

  // helper values
  logic [CNT_W-1:0]  cfg_eff;
  logic              a_ok, b_ok;
  blca_pkg::row_t    root_row;
  blca_pkg::node_t   leaf_depth;
  logic [LVL_W-1:0]  lvl_prev;
  blca_pkg::node_t   leaf_x;
  blca_pkg::node_t   diff_ab, diff_ba;
  logic [LVL_W-1:0]  lift_r;
  blca_pkg::node_t   lift_nu;
  blca_pkg::node_t   desc_pu, desc_pv;
  logic              out_free;

  blca_table u_blca_table (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  // configuration: clamp the count and derive the level bounds on each write
  assign cfg_eff     = blca_pkg::eff_count(cfg_i.node_count);
  assign cfg_i.ready = 1'b1;

  // range checks on the incoming word
  assign a_ok = {1'b0, req_i.node_a} < cnt_q;
  assign b_ok = {1'b0, req_i.node_b} < cnt_q;

  // row written by add_root
  always_comb begin
    root_row        = blca_pkg::ROW_NONE;
    root_row.parent = {1'b0, req_i.node_a};
    root_row.depth  = '0;
    root_row.root   = {1'b0, req_i.node_a};
  end

  // parent depth plus one, saturating; zero for a parent with no depth
  always_comb begin
    priority if (rdata.depth[NODE_W-1]) begin
      leaf_depth = '0;
    end else if (rdata.depth == blca_pkg::DEPTH_MAX) begin
      leaf_depth = blca_pkg::DEPTH_MAX;
    end else begin
      leaf_depth = rdata.depth + NODE_W'(1);
    end
  end

  // jump fill and lift/descent datapath
  assign lvl_prev = lvl_q - LVL_W'(1);
  assign leaf_x   = rowu_q.jump[lvl_prev];
  assign diff_ab  = rowu_q.depth - rdata.depth;
  assign diff_ba  = rdata.depth - rowu_q.depth;
  assign lift_r   = blca_pkg::floor_log2({1'b0, dist_q});
  assign lift_nu  = rowu_q.jump[lift_r];
  assign desc_pu  = rowu_q.jump[lvl_q];
  assign desc_pv  = rowv_q.jump[lvl_q];
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.answer_node = $signed(out_data_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    a_d         = a_q;
    b_d         = b_q;
    u_d         = u_q;
    v_d         = v_q;
    rowu_d      = rowu_q;
    rowv_d      = rowv_q;
    dist_d      = dist_q;
    lvl_d       = lvl_q;
    ans_d       = ans_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_data_d  = out_data_q;
    wr          = '0;
    rd          = '0;

    unique case (state_q)
      // sweep every row to none after reset
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_q;
        wr.row  = blca_pkg::ROW_NONE;
        clr_d   = clr_q + ID_W'(1);
        if (clr_q == ID_W'(blca_pkg::MAX_NODES - 1)) state_d = S_IDLE;
      end

      // take a request word and start the first table access
      S_IDLE: begin
        if (req_i.valid) begin
          a_d     = req_i.node_a;
          b_d     = req_i.node_b;
          ans_d   = blca_pkg::NODE_NONE;
          state_d = S_DONE;
          unique case (blca_pkg::cmd_e'(req_i.command))
            blca_pkg::CMD_ADD_ROOT: begin
              if (a_ok) begin
                wr.en   = 1'b1;
                wr.addr = req_i.node_a;
                wr.row  = root_row;
              end
            end
            blca_pkg::CMD_ADD_LEAF: begin
              if (a_ok && b_ok) begin
                rd.en   = 1'b1;
                rd.addr = req_i.node_b;
                state_d = S_LEAF_B;
              end
            end
            blca_pkg::CMD_QUERY_LCA: begin
              if (a_ok && b_ok) begin
                rd.en   = 1'b1;
                rd.addr = req_i.node_a;
                state_d = S_Q_A;
              end
            end
            blca_pkg::CMD_GET_PARENT: begin
              if (a_ok) begin
                rd.en   = 1'b1;
                rd.addr = req_i.node_a;
                state_d = S_GP;
              end
            end
            default: ;
          endcase
        end
      end

      // parent row in hand: start the new row, level zero is the parent
      S_LEAF_B: begin
        rowu_d         = blca_pkg::ROW_NONE;
        rowu_d.parent  = {1'b0, b_q};
        rowu_d.depth   = leaf_depth;
        rowu_d.root    = rdata.root;
        rowu_d.jump[0] = {1'b0, b_q};
        lvl_d          = LVL_W'(1);
        state_d        = S_LEAF_STEP;
      end

      // next level: ancestor of the previous level's ancestor
      S_LEAF_STEP: begin
        priority if (lvl_q >= used_q || leaf_x[NODE_W-1]) begin
          state_d = S_LEAF_WR;
        end else if (leaf_x == {1'b0, a_q}) begin
          // the node itself: its new row already holds the answer
          rowu_d.jump[lvl_q] = leaf_x;
          lvl_d              = lvl_q + LVL_W'(1);
        end else begin
          rd.en   = 1'b1;
          rd.addr = leaf_x[ID_W-1:0];
          state_d = S_LEAF_GOT;
        end
      end

      S_LEAF_GOT: begin
        rowu_d.jump[lvl_q] = rdata.jump[lvl_prev];
        lvl_d              = lvl_q + LVL_W'(1);
        state_d            = S_LEAF_STEP;
      end

      S_LEAF_WR: begin
        wr.en   = 1'b1;
        wr.addr = a_q;
        wr.row  = rowu_q;
        state_d = S_DONE;
      end

      // query: fetch both rows back to back
      S_Q_A: begin
        rowu_d  = rdata;
        rd.en   = 1'b1;
        rd.addr = b_q;
        state_d = S_Q_B;
      end

      // same tree check, deeper node goes to u
      S_Q_B: begin
        priority if (rowu_q.root != rdata.root || rowu_q.root == blca_pkg::NODE_NONE) begin
          state_d = S_DONE;
        end else if ($signed(rowu_q.depth) < $signed(rdata.depth)) begin
          u_d     = {1'b0, b_q};
          v_d     = {1'b0, a_q};
          rowv_d  = rowu_q;
          rowu_d  = rdata;
          dist_d  = diff_ba[ID_W-1:0];
          state_d = S_LIFT;
        end else begin
          u_d     = {1'b0, a_q};
          v_d     = {1'b0, b_q};
          rowv_d  = rdata;
          dist_d  = diff_ab[ID_W-1:0];
          state_d = S_LIFT;
        end
      end

      // lift u by the highest remaining power of two
      S_LIFT: begin
        priority if (dist_q == '0) begin
          if (u_q == v_q) begin
            ans_d   = u_q;
            state_d = S_DONE;
          end else begin
            lvl_d   = top_q;
            state_d = S_DESC;
          end
        end else if (lift_r >= used_q || lift_nu[NODE_W-1]) begin
          state_d = S_DONE;
        end else begin
          u_d     = lift_nu;
          dist_d  = dist_q - (ID_W'(1) << lift_r);
          rd.en   = 1'b1;
          rd.addr = lift_nu[ID_W-1:0];
          state_d = S_LIFT_GOT;
        end
      end

      S_LIFT_GOT: begin
        rowu_d  = rdata;
        state_d = S_LIFT;
      end

      // descend: move both nodes while their ancestors differ
      S_DESC: begin
        priority if (desc_pu != blca_pkg::NODE_NONE && desc_pu != desc_pv) begin
          u_d     = desc_pu;
          v_d     = desc_pv;
          rd.en   = 1'b1;
          rd.addr = desc_pu[ID_W-1:0];
          state_d = S_DESC_U;
        end else if (lvl_q == '0) begin
          state_d = S_PARENT;
        end else begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end

      S_DESC_U: begin
        rowu_d = rdata;
        priority if (!v_q[NODE_W-1]) begin
          rd.en   = 1'b1;
          rd.addr = v_q[ID_W-1:0];
          state_d = S_DESC_V;
        end else begin
          // a none node has no ancestors
          rowv_d = blca_pkg::ROW_NONE;
          if (lvl_q == '0) begin
            state_d = S_PARENT;
          end else begin
            lvl_d   = lvl_q - LVL_W'(1);
            state_d = S_DESC;
          end
        end
      end

      S_DESC_V: begin
        rowv_d = rdata;
        if (lvl_q == '0) begin
          state_d = S_PARENT;
        end else begin
          lvl_d   = lvl_q - LVL_W'(1);
          state_d = S_DESC;
        end
      end

      S_PARENT: begin
        ans_d   = rowu_q.parent;
        state_d = S_DONE;
      end

      S_GP: begin
        ans_d   = rdata.parent;
        state_d = S_DONE;
      end

      // hand the answer to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = ans_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= CNT_W'(blca_pkg::MAX_NODES);
      used_q      <= blca_pkg::levels_used(CNT_W'(blca_pkg::MAX_NODES));
      top_q       <= blca_pkg::top_level(CNT_W'(blca_pkg::MAX_NODES));
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        cnt_q  <= cfg_eff;
        used_q <= blca_pkg::levels_used(cfg_eff);
        top_q  <= blca_pkg::top_level(cfg_eff);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    u_q        <= u_d;
    v_q        <= v_d;
    rowu_q     <= rowu_d;
    rowv_q     <= rowv_d;
    dist_q     <= dist_d;
    lvl_q      <= lvl_d;
    ans_q      <= ans_d;
    out_data_q <= out_data_d;
  end

endmodule

FILE: src/blca_checker.sv
// port-level checks for the lca forest unit, bound to its top level
// depends on blca_pkg and the top level's channel ports

module blca_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [blca_pkg::NODE_W-1:0] rsp_answer_i
);

  logic [1:0] pend_q, pend_d;
  logic       req_acc, rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // requests taken minus answers delivered
  always_comb begin
    pend_d = pend_q;
    if (req_acc && !rsp_acc) pend_d = pend_q + 2'd1;
    if (rsp_acc && !req_acc) pend_d = pend_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // a stalled answer word stays
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("answer word dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_answer_i))
    else $error("answer word changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("request taken while another is in work");

  // every answer belongs to a request
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("answer word without a request");

  // ready only with room for one more answer
  a_idle_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_i |-> pend_q <= 2'd1)
    else $error("ready while two answers are owed");

endmodule

bind binary_lifting_lca_forest_unit blca_checker u_blca_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_answer_i (rsp_o.answer_node)
);

FILE: bench/binary_lifting_lca_forest_unit_test.sv
// self-checking bench for the lca forest unit: directed and random command words,
// answers checked against a mirror of the forest tables kept in the bench
// depends on blca_pkg, the three channel interfaces and the unit itself

module binary_lifting_lca_forest_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import blca_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_TAIL  = 60;
  localparam int DEPTH_CAP   = 1023;
  localparam int SELF_HANG   = 40;
  localparam int REPORT_MAX  = 10;

  typedef logic signed [NODE_W-1:0] nid_t;
  localparam nid_t NID_NONE = '1;

  // one answer still owed by the unit, with the command word that caused it
  typedef struct {
    cmd_e cmd;
    int   a;
    int   b;
    nid_t answer;
  } owed_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  blca_req_if req_if ();
  blca_rsp_if rsp_if ();
  blca_cfg_if cfg_if ();

  binary_lifting_lca_forest_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // mirror of the forest tables and the count register
  nid_t             par_tbl  [MAX_NODES];
  nid_t             dep_tbl  [MAX_NODES];
  nid_t             root_tbl [MAX_NODES];
  nid_t             jmp_tbl  [MAX_NODES][LOG_LEVELS];
  logic [CNT_W-1:0] count_reg;

  owed_t       answer_q[$];
  int          mismatches = 0;
  int unsigned cycle_cnt  = 0;
  int          burst_left = 0;
  bit          gaps_on    = 1'b1;
  int          hold_trig  = 0;

  // ---------------------------------------------------------------- forest mirror

  function automatic void clear_forest();
    for (int i = 0; i < MAX_NODES; i++) begin
      par_tbl[i]  = NID_NONE;
      dep_tbl[i]  = NID_NONE;
      root_tbl[i] = NID_NONE;
      for (int j = 0; j < LOG_LEVELS; j++) jmp_tbl[i][j] = NID_NONE;
    end
    count_reg = CNT_W'(MAX_NODES);
  endfunction

  // count as the unit uses it, clamped into 1..MAX_NODES
  function automatic int unsigned live_count();
    int unsigned c;
    c = count_reg;
    if (c == 0) c = 1;
    if (c > MAX_NODES) c = MAX_NODES;
    return c;
  endfunction

  // jump levels filled and allowed while lifting
  function automatic int span_levels(int unsigned c);
    int j;
    j = 1;
    while (j < LOG_LEVELS && (1 << j) < c) j++;
    return j;
  endfunction

  function automatic int high_bit(int unsigned x);
    int r;
    r = 0;
    while (x > 1) begin
      x = x >> 1;
      r++;
    end
    return r;
  endfunction

  // 2^lvl-th ancestor, none for any id or level off the table
  function automatic int ancestor(int n, int lvl);
    if (n < 0 || n >= MAX_NODES || lvl < 0 || lvl >= LOG_LEVELS) return -1;
    return int'(jmp_tbl[n][lvl]);
  endfunction

  function automatic nid_t common_ancestor(int u, int v, int unsigned c);
    int used;
    int top;
    int climb;
    int r;
    int t;
    int pu;
    int pv;
    used = span_levels(c);
    if (root_tbl[u] != root_tbl[v] || root_tbl[u] == NID_NONE) return NID_NONE;
    if (dep_tbl[u] < dep_tbl[v]) begin
      t = u;
      u = v;
      v = t;
    end
    // lift the deeper node to the depth of the other
    climb = int'(dep_tbl[u]) - int'(dep_tbl[v]);
    while (climb > 0) begin
      r = high_bit(climb);
      if (r >= used) return NID_NONE;
      u = ancestor(u, r);
      if (u < 0) return NID_NONE;
      climb -= 1 << r;
    end
    if (u == v) return nid_t'(u);
    // descend from the top level while the ancestors differ
    top = high_bit(c);
    if (top > LOG_LEVELS - 1) top = LOG_LEVELS - 1;
    for (int j = top; j >= 0; j--) begin
      pu = ancestor(u, j);
      pv = ancestor(v, j);
      if (pu != -1 && pu != pv) begin
        u = pu;
        v = pv;
      end
    end
    return par_tbl[u];
  endfunction

  // apply one command word to the mirror and return the answer it owes
  function automatic nid_t forest_step(cmd_e cmd, int a, int b);
    int unsigned c;
    int          used;
    int          d;
    int          nxt;
    nid_t        ans;
    nid_t        rt;
    c   = live_count();
    ans = NID_NONE;
    case (cmd)
      CMD_ADD_ROOT: begin
        if (a < c) begin
          par_tbl[a]  = nid_t'(a);
          dep_tbl[a]  = '0;
          root_tbl[a] = nid_t'(a);
          for (int j = 0; j < LOG_LEVELS; j++) jmp_tbl[a][j] = NID_NONE;
        end
      end
      CMD_ADD_LEAF: begin
        if (a < c && b < c) begin
          used = span_levels(c);
          d    = int'(dep_tbl[b]) + 1;
          if (d > DEPTH_CAP) d = DEPTH_CAP;
          if (d < 0) d = 0;
          rt            = root_tbl[b];
          par_tbl[a]    = nid_t'(b);
          dep_tbl[a]    = nid_t'(d);
          root_tbl[a]   = rt;
          jmp_tbl[a][0] = nid_t'(b);
          for (int j = 1; j < LOG_LEVELS; j++) begin
            nxt = -1;
            if (j < used) nxt = ancestor(int'(jmp_tbl[a][j-1]), j - 1);
            jmp_tbl[a][j] = nid_t'(nxt);
          end
        end
      end
      CMD_QUERY_LCA: begin
        if (a < c && b < c) ans = common_ancestor(a, b, c);
      end
      default: begin
        if (a < c) ans = par_tbl[a];
      end
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------- channel drivers

  // offer one command word, idling first when a burst has run out and gaps are on
  task automatic send_word(cmd_e cmd, int a, int b);
    owed_t item;
    if (burst_left == 0) begin
      if (gaps_on) begin
        req_if.valid   <= 1'b0;
        req_if.command <= 2'($urandom_range(0, 3));
        req_if.node_a  <= ID_W'($urandom_range(0, 1023));
        req_if.node_b  <= ID_W'($urandom_range(0, 1023));
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.node_a  <= ID_W'(a);
    req_if.node_b  <= ID_W'(b);
    forever begin
      @(negedge clk_i);
      if (req_if.ready) break;
      @(posedge clk_i);
    end
    item.cmd    = cmd;
    item.a      = a;
    item.b      = b;
    item.answer = forest_step(cmd, a, b);
    answer_q    = {answer_q, item};
    @(posedge clk_i);
  endtask

  // stop offering and wait until every owed answer has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (answer_q.size() != 0);
  endtask

  // write the node count register; only called with the unit idle
  task automatic set_count(logic [CNT_W-1:0] v);
    cfg_if.valid      <= 1'b1;
    cfg_if.node_count <= v;
    forever begin
      @(negedge clk_i);
      if (cfg_if.ready) break;
      @(posedge clk_i);
    end
    count_reg = v;
    @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // nothing added yet: every lookup answers none
  task automatic test_empty_forest();
    send_word(CMD_GET_PARENT, 0, 0);
    send_word(CMD_GET_PARENT, 1023, 0);
    send_word(CMD_QUERY_LCA, 0, 1023);
  endtask

  // extreme ids, all commands, roots as their own parent, a parent never added
  task automatic test_extremes();
    wait_drained();
    set_count(CNT_W'(1024));
    send_word(CMD_ADD_ROOT, 1023, 0);
    send_word(CMD_ADD_ROOT, 0, 1023);
    send_word(CMD_ADD_LEAF, 512, 0);
    send_word(CMD_ADD_LEAF, 341, 512);
    send_word(CMD_ADD_LEAF, 682, 341);
    send_word(CMD_QUERY_LCA, 682, 512);
    send_word(CMD_QUERY_LCA, 341, 1023);
    send_word(CMD_GET_PARENT, 1023, 0);
    send_word(CMD_ADD_LEAF, 700, 900);
    send_word(CMD_QUERY_LCA, 700, 700);
    send_word(CMD_GET_PARENT, 700, 0);
    send_word(CMD_QUERY_LCA, 1023, 1023);
  endtask

  // count zero acts as one, counts above the table act as the full table
  task automatic test_count_clamp();
    wait_drained();
    set_count('0);
    send_word(CMD_ADD_ROOT, 0, 0);
    send_word(CMD_ADD_ROOT, 1, 0);
    send_word(CMD_GET_PARENT, 1, 0);
    send_word(CMD_QUERY_LCA, 0, 0);
    wait_drained();
    set_count('1);
    send_word(CMD_GET_PARENT, 1023, 0);
  endtask

  // a middle node re-added as root leaves a chain that lifting cannot follow
  task automatic test_broken_chain();
    wait_drained();
    set_count(CNT_W'(8));
    send_word(CMD_ADD_ROOT, 0, 0);
    for (int i = 1; i < 6; i++) send_word(CMD_ADD_LEAF, i, i - 1);
    send_word(CMD_QUERY_LCA, 5, 0);
    send_word(CMD_ADD_ROOT, 1, 0);
    send_word(CMD_QUERY_LCA, 5, 0);
    send_word(CMD_QUERY_LCA, 5, 4);
    send_word(CMD_GET_PARENT, 8, 0);
    send_word(CMD_ADD_LEAF, 8, 0);
  endtask

  // answers held back for a long stretch while words keep coming
  task automatic test_backpressure();
    int known[6] = '{0, 341, 512, 682, 700, 1023};
    wait_drained();
    set_count(CNT_W'(1024));
    gaps_on = 1'b0;
    hold_trig++;
    for (int k = 0; k < 24; k++) begin
      send_word(cmd_e'($urandom_range(2, 3)), known[$urandom_range(0, 5)],
                known[$urandom_range(0, 5)]);
    end
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // a node hung under itself over and over so its depth keeps climbing
  task automatic test_self_parent();
    wait_drained();
    set_count(CNT_W'(2));
    send_word(CMD_ADD_ROOT, 0, 0);
    send_word(CMD_ADD_LEAF, 1, 0);
    for (int k = 0; k < SELF_HANG; k++) send_word(CMD_ADD_LEAF, 1, 1);
    send_word(CMD_GET_PARENT, 1, 0);
    send_word(CMD_QUERY_LCA, 1, 0);
    send_word(CMD_QUERY_LCA, 1, 1);
  endtask

  // random trees: roots, leaves under recent nodes, queries among known nodes, noise
  task automatic test_random_trees(logic [CNT_W-1:0] cnt, int n_items, bit deep);
    int          pool[$];
    int unsigned c;
    int          r;
    int          a;
    int          b;
    int          span;
    cmd_e        cmd;
    wait_drained();
    set_count(cnt);
    c       = live_count();
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      a = $urandom_range(0, c - 1);
      b = $urandom_range(0, c - 1);
      if (pool.size() == 0 || r < 10) begin
        cmd = CMD_ADD_ROOT;
      end else if (r < 50) begin
        // parent mostly among the newest nodes so that chains grow deep
        cmd  = CMD_ADD_LEAF;
        span = (pool.size() > 4) ? 3 : pool.size() - 1;
        if (deep && $urandom_range(0, 9) != 0) b = pool[$];
        else if ($urandom_range(0, 1)) b = pool[pool.size() - 1 - $urandom_range(0, span)];
        else b = pool[$urandom_range(0, pool.size() - 1)];
        if ($urandom_range(0, 19) == 0) b = $urandom_range(0, c - 1);
      end else if (r < 82) begin
        cmd = CMD_QUERY_LCA;
        if ($urandom_range(0, 99) < 85) begin
          a = pool[$urandom_range(0, pool.size() - 1)];
          b = pool[$urandom_range(0, pool.size() - 1)];
        end
      end else if (r < 94) begin
        cmd = CMD_GET_PARENT;
        if ($urandom_range(0, 9) < 7) a = pool[$urandom_range(0, pool.size() - 1)];
      end else begin
        cmd = cmd_e'($urandom_range(0, 3));
        a   = $urandom_range(0, 1023);
        b   = $urandom_range(0, 1023);
      end
      send_word(cmd, a, b);
      if ((cmd == CMD_ADD_ROOT || cmd == CMD_ADD_LEAF) && a < c) pool = {pool, a};
      if (pool.size() > 200) void'(pool.pop_front());
    end
  endtask

  // ---------------------------------------------------------------- answer checker

  initial begin : answer_check
    nid_t  got;
    owed_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got = rsp_if.answer_node;
        @(posedge clk_i);
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("answer word %0d arrived with nothing owed", got);
        end else begin
          want = answer_q.pop_front();
          if (got !== want.answer) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("answer mismatch: %s a=%0d b=%0d expected %0d actual %0d",
                       want.cmd.name(), want.a, want.b, want.answer, got);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- answer receiver

  // ready pattern switches at random among always, mostly and half ready; long hold on request
  initial begin : answer_sink
    int hold_seen;
    int hold_left;
    int mode;
    int period_left;
    hold_seen    = 0;
    hold_left    = 0;
    mode         = 0;
    period_left  = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        hold_left = LONG_HOLD;
      end
      if (period_left == 0) begin
        mode        = $urandom_range(0, 2);
        period_left = $urandom_range(16, 96);
      end else begin
        period_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
          default: rsp_if.ready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- run limit

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("binary_lifting_lca_forest_unit_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.command    = '0;
    req_if.node_a     = '0;
    req_if.node_b     = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.node_count = '0;
    clear_forest();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_forest();
    test_extremes();
    test_count_clamp();
    test_broken_chain();
    test_backpressure();
    test_self_parent();
    test_random_trees(CNT_W'(1024), 150, 1'b1);
    test_random_trees(CNT_W'(64), 100, 1'b0);
    test_random_trees(CNT_W'(5), 50, 1'b0);
    test_random_trees(CNT_W'($urandom_range(1, 2047)), 80, 1'b0);
    test_random_trees(CNT_W'(300), 100, 1'b1);
    test_random_trees('1, 70, 1'b0);

    // let any late answer show up before the verdict
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("binary_lifting_lca_forest_unit_test: PASS");
    end else begin
      $display("binary_lifting_lca_forest_unit_test: FAIL");
    end
    $finish;
  end

endmodule
